>>> rtl/mcfp_pkg.sv
package mcfp_pkg;

  // Frame layout
  localparam int FRAME_LENGTH = 5;
  localparam int POS_W        = 3;

  // Frame byte codes (ASCII)
  localparam logic [7:0] HEADER_BYTE = 8'h23;  // '#'
  localparam logic [7:0] DIGIT_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] DIGIT_NINE  = 8'h39;  // '9'
  localparam logic [7:0] SIDE_LEFT   = 8'h6C;  // 'l'
  localparam logic [7:0] SIDE_RIGHT  = 8'h72;  // 'r'
  localparam logic [7:0] DIR_FWD     = 8'h66;  // 'f'
  localparam logic [7:0] DIR_STOP    = 8'h73;  // 's'
  localparam logic [7:0] DIR_REV     = 8'h72;  // 'r'

  // Configuration register map
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_FACTOR   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FULL_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FULL_DUTY      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_DUTY      = 2'd3;

  localparam int SCALE_W = 4;
  localparam int LEVEL_W = 10;
  localparam int VALUE_W = 7;   // two-digit value, 0..99
  localparam int SPEED_W = VALUE_W + SCALE_W;

  localparam logic [SCALE_W-1:0] SCALE_RESET     = 4'd3;
  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 10'd280;
  localparam logic [LEVEL_W-1:0] FULL_RESET      = 10'd800;
  localparam logic [LEVEL_W-1:0] STOP_RESET      = 10'd800;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_factor;
    logic [LEVEL_W-1:0] full_threshold;
    logic [LEVEL_W-1:0] full_duty;
    logic [LEVEL_W-1:0] stop_duty;
  } cfg_t;

  // Fields latched from the first bytes of a frame
  typedef struct packed {
    logic [7:0] side_char;
    logic [7:0] direction_char;
    logic [3:0] tens_digit;
    logic       digit_bad;
  } frame_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
  endfunction

endpackage

>>> rtl/motor_command_frame_parser.sv
// Channel  Handshake             Payload                                     Dir
// -------  --------------------  ------------------------------------------  ---
// input    in_valid / in_ready   rx_byte[7:0]                                in
// output   out_valid / out_ready motor_side, forward_duty, reverse_duty      out
// config   cfg_we (no wait)      cfg_index[1:0], cfg_data[9:0]               in
//
// One byte per cycle is accepted while in_ready is high; a result appears in the output register the
// cycle after the final frame byte is transferred.
// Latency is set by the single result register after the final-byte logic.
// in_ready drops only while a result is held and out_ready is low.
// rst (synchronous) clears the frame position, the output valid and restores
// the configuration defaults.
module motor_command_frame_parser #(
  parameter int DUTY_WIDTH = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // byte input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          rx_byte,
  // duty update output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                motor_side,
  output logic [DUTY_WIDTH-1:0]               forward_duty,
  output logic [DUTY_WIDTH-1:0]               reverse_duty,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [mcfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mcfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Frame position codes; values above POS_UNITS behave as idle
  localparam logic [mcfp_pkg::POS_W-1:0] POS_IDLE  = 3'd0;
  localparam logic [mcfp_pkg::POS_W-1:0] POS_SIDE  = 3'd1;
  localparam logic [mcfp_pkg::POS_W-1:0] POS_DIR   = 3'd2;
  localparam logic [mcfp_pkg::POS_W-1:0] POS_TENS  = 3'd3;
  localparam logic [mcfp_pkg::POS_W-1:0] POS_UNITS = mcfp_pkg::POS_W'(mcfp_pkg::FRAME_LENGTH - 1);

  mcfp_pkg::cfg_t               cfg;
  mcfp_pkg::frame_t             frame;
  mcfp_pkg::frame_t             frame_next;
  logic [mcfp_pkg::POS_W-1:0]   frame_position;
  logic [mcfp_pkg::POS_W-1:0]   frame_position_next;

  logic                         in_xfer;
  logic                         result_ok;
  logic                         res_side;
  logic [DUTY_WIDTH-1:0]        res_fwd;
  logic [DUTY_WIDTH-1:0]        res_rev;

  // Output slot is free, or is emptied in this same cycle
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_factor   <= mcfp_pkg::SCALE_RESET;
      cfg.full_threshold <= mcfp_pkg::THRESHOLD_RESET;
      cfg.full_duty      <= mcfp_pkg::FULL_RESET;
      cfg.stop_duty      <= mcfp_pkg::STOP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mcfp_pkg::CFG_SCALE_FACTOR:   cfg.scale_factor   <= cfg_data[mcfp_pkg::SCALE_W-1:0];
        mcfp_pkg::CFG_FULL_THRESHOLD: cfg.full_threshold <= cfg_data;
        mcfp_pkg::CFG_FULL_DUTY:      cfg.full_duty      <= cfg_data;
        mcfp_pkg::CFG_STOP_DUTY:      cfg.stop_duty      <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Frame tracking: header hunt, then latch side, direction, tens digit
  // ---------------------------------------------------------------------
  always_comb begin
    frame_next          = frame;
    frame_position_next = frame_position;
    case (frame_position)
      POS_SIDE: begin
        frame_next.side_char = rx_byte;
        frame_position_next  = POS_DIR;
      end
      POS_DIR: begin
        frame_next.direction_char = rx_byte;
        frame_position_next       = POS_TENS;
      end
      POS_TENS: begin
        if (mcfp_pkg::is_digit(rx_byte)) begin
          frame_next.tens_digit = 4'(rx_byte - mcfp_pkg::DIGIT_ZERO);
          frame_next.digit_bad  = 1'b0;
        end else begin
          frame_next.tens_digit = 4'd0;
          frame_next.digit_bad  = 1'b1;
        end
        frame_position_next = POS_UNITS;
      end
      POS_UNITS: begin
        // final byte: evaluated by the duty unit, frame closes
        frame_position_next = POS_IDLE;
      end
      default: begin
        frame_position_next = (rx_byte == mcfp_pkg::HEADER_BYTE) ? POS_SIDE : POS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= POS_IDLE;
      frame          <= '0;
    end else if (in_xfer) begin
      frame_position <= frame_position_next;
      frame          <= frame_next;
    end
  end

  // ---------------------------------------------------------------------
  // Final-byte evaluation
  // ---------------------------------------------------------------------
  mcfp_duty #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_duty (
    .cfg        (cfg),
    .frame      (frame),
    .units_byte (rx_byte),
    .result_ok  (result_ok),
    .side       (res_side),
    .fwd_duty   (res_fwd),
    .rev_duty   (res_rev)
  );

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && frame_position == POS_UNITS && result_ok) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && frame_position == POS_UNITS && result_ok) begin
      motor_side   <= res_side;
      forward_duty <= res_fwd;
      reverse_duty <= res_rev;
    end
  end

endmodule

>>> rtl/mcfp_duty.sv
// Final-byte evaluation: decode side/direction, scale, clamp, pick pair.
module mcfp_duty #(
  parameter int DUTY_WIDTH = 10
) (
  input  mcfp_pkg::cfg_t         cfg,
  input  mcfp_pkg::frame_t       frame,
  input  logic [7:0]             units_byte,
  output logic                   result_ok,
  output logic                   side,
  output logic [DUTY_WIDTH-1:0]  fwd_duty,
  output logic [DUTY_WIDTH-1:0]  rev_duty
);

  logic                             side_ok;
  logic                             dir_ok;
  logic [3:0]                       units;
  logic [mcfp_pkg::VALUE_W-1:0]     value;
  logic [mcfp_pkg::SPEED_W-1:0]     product;
  logic [mcfp_pkg::LEVEL_W-1:0]     speed;
  logic [DUTY_WIDTH-1:0]            speed_d;
  logic [DUTY_WIDTH-1:0]            stop_d;

  always_comb begin
    side_ok = 1'b1;
    side    = 1'b0;
    case (frame.side_char)
      mcfp_pkg::SIDE_LEFT:  side = 1'b0;
      mcfp_pkg::SIDE_RIGHT: side = 1'b1;
      default:              side_ok = 1'b0;
    endcase
  end

  assign units   = 4'(units_byte - mcfp_pkg::DIGIT_ZERO);
  assign value   = mcfp_pkg::VALUE_W'(frame.tens_digit) * mcfp_pkg::VALUE_W'(10)
                 + mcfp_pkg::VALUE_W'(units);
  assign product = mcfp_pkg::SPEED_W'(value) * mcfp_pkg::SPEED_W'(cfg.scale_factor);

  // Not above threshold implies the product fits in 10 bits
  assign speed   = (product > mcfp_pkg::SPEED_W'(cfg.full_threshold)) ?
                   cfg.full_duty : product[mcfp_pkg::LEVEL_W-1:0];
  assign speed_d = DUTY_WIDTH'(speed);
  assign stop_d  = DUTY_WIDTH'(cfg.stop_duty);

  always_comb begin
    dir_ok   = 1'b1;
    fwd_duty = stop_d;
    rev_duty = stop_d;
    case (frame.direction_char)
      mcfp_pkg::DIR_FWD:  fwd_duty = speed_d;
      mcfp_pkg::DIR_REV:  rev_duty = speed_d;
      mcfp_pkg::DIR_STOP: ;
      default:            dir_ok = 1'b0;
    endcase
  end

  assign result_ok = !frame.digit_bad && mcfp_pkg::is_digit(units_byte) && side_ok && dir_ok;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  // Run bounds, in clock cycles
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 4;     // result register plus margin
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off

  // Frame position codes; the count of frame bytes already taken
  localparam logic [mcfp_pkg::POS_W-1:0] POS_IDLE  = 3'd0;
  localparam logic [mcfp_pkg::POS_W-1:0] POS_SIDE  = 3'd1;
  localparam logic [mcfp_pkg::POS_W-1:0] POS_DIR   = 3'd2;
  localparam logic [mcfp_pkg::POS_W-1:0] POS_TENS  = 3'd3;
  localparam logic [mcfp_pkg::POS_W-1:0] POS_UNITS = 3'(mcfp_pkg::FRAME_LENGTH - 1);

  typedef struct {
    logic                         side;
    logic [mcfp_pkg::LEVEL_W-1:0] fwd;
    logic [mcfp_pkg::LEVEL_W-1:0] rev;
  } duty_upd_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_ready;
  logic motor_side;
  logic [mcfp_pkg::LEVEL_W-1:0] forward_duty;
  logic [mcfp_pkg::LEVEL_W-1:0] reverse_duty;
  logic cfg_we;
  logic [mcfp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mcfp_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predicted duty updates, oldest first
  duty_upd_t expected_updates[$];
  duty_upd_t want_upd;

  // Predictor copy of the registers
  logic [mcfp_pkg::SCALE_W-1:0] reg_scale;
  logic [mcfp_pkg::LEVEL_W-1:0] reg_threshold;
  logic [mcfp_pkg::LEVEL_W-1:0] reg_full;
  logic [mcfp_pkg::LEVEL_W-1:0] reg_stop;

  // Predictor copy of the frame state
  logic [mcfp_pkg::POS_W-1:0] frm_pos;
  logic [7:0]                 frm_side;
  logic [7:0]                 frm_dir;
  logic [3:0]                 frm_tens;
  logic                       frm_bad;

  int  fail_count  = 0;
  int  cycle_count = 0;
  bit  tx_idle_on  = 1'b1;   // sender inserts random gaps
  bit  rx_idle_on  = 1'b1;   // receiver inserts random stalls
  int  rx_hold_req = 0;      // long hold-off request, picked up by receiver
  int  rx_hold     = 0;
  int  rx_stall    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  motor_command_frame_parser u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .motor_side  (motor_side),
    .forward_duty(forward_duty),
    .reverse_duty(reverse_duty),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic bit ascii_digit(input logic [7:0] b);
    return (b >= mcfp_pkg::DIGIT_ZERO) && (b <= mcfp_pkg::DIGIT_ZERO + 8'd9);
  endfunction

  // ---------------------------------------------------------------------
  // Predictor: advance the frame state by one accepted byte and queue the
  // duty update that the final byte of a good frame produces.
  // ---------------------------------------------------------------------
  task automatic predict_byte(input logic [7:0] b);
    int        value;
    int        speed;
    bit        side_ok;
    bit        dir_ok;
    duty_upd_t upd;
    case (frm_pos)
      POS_SIDE: begin
        frm_side = b;
        frm_pos  = POS_DIR;
      end
      POS_DIR: begin
        frm_dir = b;
        frm_pos = POS_TENS;
      end
      POS_TENS: begin
        // a bad tens digit is remembered and kills the frame at the end
        if (ascii_digit(b)) begin
          frm_tens = 4'(b - mcfp_pkg::DIGIT_ZERO);
          frm_bad  = 1'b0;
        end else begin
          frm_tens = 4'd0;
          frm_bad  = 1'b1;
        end
        frm_pos = POS_UNITS;
      end
      POS_UNITS: begin
        frm_pos = POS_IDLE;
        value   = int'(frm_tens) * 10 + int'(8'(b - mcfp_pkg::DIGIT_ZERO));
        speed   = value * int'(reg_scale);
        // only strictly above the threshold takes the full duty
        if (speed > int'(reg_threshold)) speed = int'(reg_full);
        side_ok  = (frm_side == mcfp_pkg::SIDE_LEFT) || (frm_side == mcfp_pkg::SIDE_RIGHT);
        upd.side = (frm_side == mcfp_pkg::SIDE_RIGHT);
        dir_ok   = 1'b1;
        if (frm_dir == mcfp_pkg::DIR_FWD) begin
          upd.fwd = mcfp_pkg::LEVEL_W'(speed);
          upd.rev = reg_stop;
        end else if (frm_dir == mcfp_pkg::DIR_REV) begin
          upd.fwd = reg_stop;
          upd.rev = mcfp_pkg::LEVEL_W'(speed);
        end else if (frm_dir == mcfp_pkg::DIR_STOP) begin
          upd.fwd = reg_stop;
          upd.rev = reg_stop;
        end else begin
          dir_ok = 1'b0;
        end
        if (!frm_bad && ascii_digit(b) && side_ok && dir_ok)
          expected_updates.push_back(upd);
      end
      default: begin
        // idle (and any unused position): hunt for the header
        frm_pos = (b == mcfp_pkg::HEADER_BYTE) ? POS_SIDE : POS_IDLE;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Byte sender. Valid is left high after the transfer; the next call
  // either reuses it at once or drops it for a gap.
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] side, input logic [7:0] dir,
                            input logic [7:0] tens, input logic [7:0] units);
    send_byte(mcfp_pkg::HEADER_BYTE);
    send_byte(side);
    send_byte(dir);
    send_byte(tens);
    send_byte(units);
  endtask

  // Drop valid, let every predicted update arrive, then let the block
  // settle so a frame that produced nothing is finished too.
  task automatic wait_idle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_updates.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_updates.size() != 0) begin
      $error("%0d expected duty updates never arrived", expected_updates.size());
      fail_count++;
      expected_updates.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mcfp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mcfp_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes all four registers back to back; only called while idle
  task automatic load_config(input logic [mcfp_pkg::SCALE_W-1:0] scale,
                             input logic [mcfp_pkg::LEVEL_W-1:0] thr,
                             input logic [mcfp_pkg::LEVEL_W-1:0] full,
                             input logic [mcfp_pkg::LEVEL_W-1:0] stop);
    write_reg(mcfp_pkg::CFG_SCALE_FACTOR, mcfp_pkg::CFG_DATA_W'(scale));
    write_reg(mcfp_pkg::CFG_FULL_THRESHOLD, thr);
    write_reg(mcfp_pkg::CFG_FULL_DUTY, full);
    write_reg(mcfp_pkg::CFG_STOP_DUTY, stop);
    cfg_we        <= 1'b0;
    reg_scale     = scale;
    reg_threshold = thr;
    reg_full      = full;
    reg_stop      = stop;
  endtask

  function automatic logic [7:0] rand_digit_byte();
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return mcfp_pkg::DIGIT_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed frames with random content, some noise between
  task automatic send_random_frame();
    int         pick;
    logic [7:0] side;
    logic [7:0] dir;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    pick = $urandom_range(0, 19);
    if (pick < 18) side = (pick % 2) ? mcfp_pkg::SIDE_RIGHT : mcfp_pkg::SIDE_LEFT;
    else           side = 8'($urandom);
    pick = $urandom_range(0, 19);
    if (pick < 6)       dir = mcfp_pkg::DIR_FWD;
    else if (pick < 12) dir = mcfp_pkg::DIR_REV;
    else if (pick < 18) dir = mcfp_pkg::DIR_STOP;
    else                dir = 8'($urandom);
    send_frame(side, dir, rand_digit_byte(), rand_digit_byte());
  endtask

  // ---------------------------------------------------------------------
  // Receiver: checks each transfer against the oldest prediction, then
  // draws its stall for the next one. A long hold-off overrides.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          $error("unexpected duty update: side %0d fwd %0d rev %0d",
                 motor_side, forward_duty, reverse_duty);
          fail_count++;
        end else begin
          want_upd = expected_updates.pop_front();
          if (motor_side !== want_upd.side) begin
            $error("motor_side: expected %0d, got %0d", want_upd.side, motor_side);
            fail_count++;
          end
          if (forward_duty !== want_upd.fwd) begin
            $error("forward_duty: expected %0d, got %0d", want_upd.fwd, forward_duty);
            fail_count++;
          end
          if (reverse_duty !== want_upd.rev) begin
            $error("reverse_duty: expected %0d, got %0d", want_upd.rev, reverse_duty);
            fail_count++;
          end
        end
        rx_stall = rx_idle_on ? $urandom_range(0, 19) : 0;
      end
      if (rx_hold_req > 0) begin
        rx_hold     = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset register values: idle junk, a plain forward, a product above
  // the threshold, and a stop.
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(mcfp_pkg::SIDE_LEFT, mcfp_pkg::DIR_FWD, "5", "0");    // 150, stop on reverse
    send_frame(mcfp_pkg::SIDE_RIGHT, mcfp_pkg::DIR_REV, "9", "9");   // 297 > 280: full duty
    send_frame(mcfp_pkg::SIDE_LEFT, mcfp_pkg::DIR_STOP, "0", "0");
    wait_idle();
  endtask

  // Frames that are consumed with no update
  task automatic test_malformed_frames();
    send_frame(mcfp_pkg::HEADER_BYTE, mcfp_pkg::DIR_FWD, "1", "2");  // header taken as side
    send_frame(mcfp_pkg::SIDE_LEFT, "x", "3", "4");                  // unknown direction
    send_frame(mcfp_pkg::SIDE_RIGHT, mcfp_pkg::DIR_FWD, "/", "9");   // tens below '0'
    wait_idle();
  endtask

  // Receiver holds off while the sender streams, so the result register
  // fills and the input side has to stall.
  task automatic test_output_backpressure();
    load_config(4'($urandom_range(1, 15)), 10'($urandom), 10'($urandom), 10'($urandom));
    tx_idle_on  = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    repeat (12) send_frame(mcfp_pkg::SIDE_RIGHT, mcfp_pkg::DIR_FWD,
                           rand_digit_byte(), rand_digit_byte());
    wait_idle();
    tx_idle_on = 1'b1;
  endtask

  // Phases of random frames under extreme and random register settings
  task automatic test_random_traffic();
    logic [mcfp_pkg::SCALE_W-1:0] scale;
    logic [mcfp_pkg::LEVEL_W-1:0] thr;
    int                           edge_thr;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: load_config(4'd0, 10'd0, 10'd0, 10'd0);
        1: load_config(4'd15, 10'd1023, 10'd1023, 10'd1023);
        2: load_config(4'd15, 10'd0, 10'd1023, 10'd0);
        3: load_config(mcfp_pkg::SCALE_RESET, mcfp_pkg::THRESHOLD_RESET,
                       mcfp_pkg::FULL_RESET, mcfp_pkg::STOP_RESET);
        default: begin
          scale = 4'($urandom);
          // half the time land the threshold on a reachable product
          edge_thr = int'(scale) * $urandom_range(0, 99);
          if (edge_thr > 1023) edge_thr = 1023;
          thr = $urandom_range(0, 1) ? 10'($urandom) : 10'(edge_thr);
          load_config(scale, thr, 10'($urandom), 10'($urandom));
        end
      endcase
      tx_idle_on = (phase % 3) != 2;
      rx_idle_on = (phase % 4) != 3;
      repeat (25) send_random_frame();
      wait_idle();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    rx_byte   <= 8'h00;
    out_ready <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= mcfp_pkg::CFG_SCALE_FACTOR;
    cfg_data  <= '0;
    reg_scale     = mcfp_pkg::SCALE_RESET;
    reg_threshold = mcfp_pkg::THRESHOLD_RESET;
    reg_full      = mcfp_pkg::FULL_RESET;
    reg_stop      = mcfp_pkg::STOP_RESET;
    frm_pos  = POS_IDLE;
    frm_side = 8'h00;
    frm_dir  = 8'h00;
    frm_tens = 4'd0;
    frm_bad  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_malformed_frames();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> motor_command_frame_parser.f
rtl/mcfp_pkg.sv
rtl/mcfp_duty.sv
rtl/motor_command_frame_parser.sv
tb/tb.sv
